// ===== rtl/core/sel_pkg.sv =====
// ----------------------------------------------------------------------------
// sel_pkg: shared types and codes for the sequenced event log
// Opcodes, the per-slot metadata record and fixed widths.
// ----------------------------------------------------------------------------
package sel_pkg;

  localparam logic [1:0] OP_CONNECT    = 2'd0;
  localparam logic [1:0] OP_DISCONNECT = 2'd1;
  localparam logic [1:0] OP_NOTIFY     = 2'd2;
  localparam logic [1:0] OP_QUERY      = 2'd3;

  localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

  // wide enough for a capacity of up to 512 bytes
  localparam int LEN_W = 10;

  typedef struct packed {
    logic [31:0]      seq;
    logic [31:0]      gen;
    logic [15:0]      handle;
    logic             ind;
    logic [LEN_W-1:0] len;
    logic             trunc;
  } meta_t;

endpackage

// ===== rtl/core/sequenced_event_log_unit.sv =====
// Notify, connect and disconnect are accepted in idle and give no result word.
// Query: a slot scan (one metadata memory read per cycle), a setup state, then
// one result word per cycle while m_tready allows, up to min(PAGE_SIZE, 16).
// One item at a time: no new item is accepted until a query has loaded its last word.
// Reset: sync active-high rst clears link, counters, run state and slot valid
// bits; metadata and payload memories are not cleared.
// ----------------------------------------------------------------------------
// sequenced_event_log_unit: ring log of notification events
// Metadata and payload live in synchronous memories; queries scan the slots.
// ----------------------------------------------------------------------------
module sequenced_event_log_unit #(
  parameter int EVENT_SLOTS    = 16,
  parameter int VALUE_CAPACITY = 256,
  parameter int PAGE_SIZE      = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // handle[15:0], is_indication[16], payload_valid[17], payload_byte[25:18],
  // cursor_after[57:26], wanted_sequence[89:58], page_offset[98:90]
  input  logic [103:0] s_tdata,
  input  logic [1:0]   s_tuser,   // opcode[1:0]
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // found[0], sequence_no[32:1], event_generation[64:33], handle_out[80:65],
  // indication_out[81], value_length[90:82], truncated_flag[91],
  // lost_count[123:92], page_byte[131:124], byte_valid[132],
  // dropped_total[164:133]
  output logic [167:0] m_tdata,
  output logic         m_tlast    // last_result
);

  localparam int SW   = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CW   = $clog2(EVENT_SLOTS + 1);
  localparam int PA_W = (EVENT_SLOTS * VALUE_CAPACITY > 1) ?
                        $clog2(EVENT_SLOTS * VALUE_CAPACITY) : 1;
  localparam int PG   = (PAGE_SIZE < 16) ? PAGE_SIZE : 16;
  localparam int LW   = sel_pkg::LEN_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;

  // input word fields
  logic [15:0] in_handle;
  logic        in_ind, in_pv;
  logic [7:0]  in_byte;
  logic [31:0] in_after, in_wanted;
  logic [8:0]  in_offset;
  assign in_handle = s_tdata[15:0];
  assign in_ind    = s_tdata[16];
  assign in_pv     = s_tdata[17];
  assign in_byte   = s_tdata[25:18];
  assign in_after  = s_tdata[57:26];
  assign in_wanted = s_tdata[89:58];
  assign in_offset = s_tdata[98:90];

  // control state
  logic [2:0]             state;
  logic                   link_up;
  logic [31:0]            link_gen, latest_seq, drop_count;
  logic [SW-1:0]          write_slot;
  logic                   run_active, run_discarded;
  logic [EVENT_SLOTS-1:0] slot_valid;
  sel_pkg::meta_t         run_meta;
  logic [SW-1:0]          run_slot;

  // memories
  sel_pkg::meta_t meta_mem [EVENT_SLOTS];
  logic [7:0]     pay_mem  [EVENT_SLOTS * VALUE_CAPACITY];
  sel_pkg::meta_t meta_rd;
  logic [7:0]     pay_rd;

  // query state
  logic [31:0]    q_after, q_wanted;
  logic [8:0]     q_offset;
  logic [CW-1:0]  scan_cnt;
  logic           eval_vld;
  logic [SW-1:0]  eval_idx;
  logic           sel_found;
  logic [SW-1:0]  sel_idx;
  sel_pkg::meta_t sel_meta;
  logic [4:0]     nbytes, res_cnt;

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // ---------------- notify item processing ----------------
  logic                   notify_go;
  logic [31:0]            latest_next, drop_next;
  logic [SW-1:0]          write_slot_next, run_slot_next;
  logic                   disc_next;
  sel_pkg::meta_t         meta_next;
  logic [EVENT_SLOTS-1:0] valid_next;
  logic                   pay_we;
  logic [PA_W-1:0]        pay_wa;

  assign notify_go = accept && (s_tuser == sel_pkg::OP_NOTIFY) && link_up;

  always_comb begin
    latest_next     = latest_seq;
    drop_next       = drop_count;
    write_slot_next = write_slot;
    run_slot_next   = run_slot;
    disc_next       = run_discarded;
    meta_next       = run_meta;
    valid_next      = slot_valid;
    pay_we          = 1'b0;
    pay_wa          = PA_W'(run_slot) * PA_W'(VALUE_CAPACITY);
    if (!run_active) begin
      if (latest_seq == sel_pkg::SEQ_MAX) begin
        if (drop_count != sel_pkg::SEQ_MAX) drop_next = drop_count + 32'd1;
        disc_next = 1'b1;
      end else begin
        if (slot_valid[write_slot] && drop_count != sel_pkg::SEQ_MAX)
          drop_next = drop_count + 32'd1;
        latest_next             = latest_seq + 32'd1;
        meta_next.seq           = latest_seq + 32'd1;
        meta_next.gen           = link_gen;
        meta_next.handle        = in_handle;
        meta_next.ind           = in_ind;
        meta_next.len           = '0;
        meta_next.trunc         = 1'b0;
        run_slot_next           = write_slot;
        disc_next               = 1'b0;
        valid_next[write_slot]  = 1'b1;
        write_slot_next = (32'(write_slot) == EVENT_SLOTS - 1) ? '0 : write_slot + 1'b1;
      end
    end
    pay_wa = PA_W'(run_slot_next) * PA_W'(VALUE_CAPACITY) + PA_W'(meta_next.len);
    if (!disc_next && in_pv) begin
      if (32'(meta_next.len) < VALUE_CAPACITY) begin
        pay_we        = 1'b1;
        meta_next.len = meta_next.len + 1'b1;
      end else begin
        meta_next.trunc = 1'b1;
      end
    end
  end

  // ---------------- query datapath ----------------
  logic           meta_re;
  logic [SW-1:0]  meta_ra;
  logic           take;
  logic           out_free;
  logic           is_last;
  logic           pay_re;
  logic [PA_W-1:0] pay_ra;
  logic [LW-1:0]  off_ext, diff;
  logic [4:0]     nb_calc, rcnt_inc;
  logic [31:0]    lost;

  assign meta_re  = (state == ST_SCAN) && (scan_cnt < CW'(EVENT_SLOTS));
  assign meta_ra  = scan_cnt[SW-1:0];
  // candidate check on the slot read last cycle
  assign take = eval_vld && slot_valid[eval_idx] &&
                ((q_wanted != 32'd0) ? (meta_rd.seq == q_wanted) :
                 (meta_rd.seq > q_after && (!sel_found || meta_rd.seq < sel_meta.seq)));

  assign off_ext = LW'(q_offset);
  assign diff    = sel_meta.len - off_ext;
  assign nb_calc = (!sel_found || off_ext >= sel_meta.len) ? 5'd0 :
                   ((diff > LW'(PG)) ? 5'(PG) : diff[4:0]);

  assign out_free = !m_tvalid || m_tready;
  assign rcnt_inc = res_cnt + 5'd1;
  assign is_last  = (nbytes == 5'd0) || (rcnt_inc == nbytes);
  // first byte read in setup, next one while the current word goes out
  assign pay_re   = (state == ST_SETUP && nb_calc != 5'd0) ||
                    (state == ST_EMIT && out_free && !is_last);
  assign pay_ra   = PA_W'(sel_idx) * PA_W'(VALUE_CAPACITY) + PA_W'(q_offset) +
                    ((state == ST_SETUP) ? '0 : PA_W'(rcnt_inc));
  assign lost     = (q_wanted == 32'd0) ? (sel_meta.seq - q_after - 32'd1) : 32'd0;

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (notify_go && !disc_next) meta_mem[run_slot_next] <= meta_next;
    if (meta_re) meta_rd <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk) begin
    if (notify_go && pay_we) pay_mem[pay_wa] <= in_byte;
    if (pay_re) pay_rd <= pay_mem[pay_ra];
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      link_up       <= 1'b0;
      link_gen      <= '0;
      latest_seq    <= '0;
      drop_count    <= '0;
      write_slot    <= '0;
      run_active    <= 1'b0;
      run_discarded <= 1'b0;
      run_slot      <= '0;
      slot_valid    <= '0;
      m_tvalid      <= 1'b0;
      scan_cnt      <= '0;
      eval_vld      <= 1'b0;
      sel_found     <= 1'b0;
    end else begin
      // a new word is loaded in emit, else the current one holds until taken
      m_tvalid <= (state == ST_EMIT && out_free) || (m_tvalid && !m_tready);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              sel_pkg::OP_CONNECT, sel_pkg::OP_DISCONNECT: begin
                slot_valid    <= '0;
                write_slot    <= '0;
                run_active    <= 1'b0;
                run_discarded <= 1'b0;
                run_slot      <= '0;
                link_up       <= (s_tuser == sel_pkg::OP_CONNECT);
                if (s_tuser == sel_pkg::OP_CONNECT) begin
                  link_gen   <= (link_gen == sel_pkg::SEQ_MAX) ? 32'd1 : link_gen + 32'd1;
                  latest_seq <= '0;
                  drop_count <= '0;
                end
              end
              sel_pkg::OP_NOTIFY: begin
                if (link_up) begin
                  latest_seq    <= latest_next;
                  drop_count    <= drop_next;
                  write_slot    <= write_slot_next;
                  run_slot      <= run_slot_next;
                  slot_valid    <= valid_next;
                  run_active    <= !s_tlast;
                  run_discarded <= s_tlast ? 1'b0 : disc_next;
                end
              end
              default: begin
                scan_cnt  <= '0;
                eval_vld  <= 1'b0;
                sel_found <= 1'b0;
                state     <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          eval_vld <= meta_re;
          if (meta_re) scan_cnt <= scan_cnt + 1'b1;
          if (take) sel_found <= 1'b1;
          if (!meta_re && !eval_vld) state <= ST_SETUP;
        end
        ST_SETUP: begin
          res_cnt <= '0;
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            res_cnt  <= rcnt_inc;
            if (is_last) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload and query registers, no reset needed
  always_ff @(posedge clk) begin
    if (notify_go && !disc_next) run_meta <= meta_next;
    if (accept && s_tuser == sel_pkg::OP_QUERY) begin
      q_after  <= in_after;
      q_wanted <= in_wanted;
      q_offset <= in_offset;
    end
    if (state == ST_SCAN) eval_idx <= meta_ra;
    if (state == ST_SCAN && take) begin
      sel_idx  <= eval_idx;
      sel_meta <= meta_rd;
    end
    if (state == ST_SETUP) nbytes <= nb_calc;
    if (state == ST_EMIT && out_free) begin
      m_tlast <= is_last;
      if (sel_found)
        m_tdata <= {3'b0, drop_count, (nbytes != 5'd0),
                    ((nbytes != 5'd0) ? pay_rd : 8'd0), lost, sel_meta.trunc,
                    sel_meta.len[8:0], sel_meta.ind, sel_meta.handle,
                    sel_meta.gen, sel_meta.seq, 1'b1};
      else
        m_tdata <= {3'b0, drop_count, 133'd0};
    end
  end

  // ---------------- assertions ----------------
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    32'(write_slot) < EVENT_SLOTS) else $error("write slot out of range");
  a_down_empty: assert property (@(posedge clk) disable iff (rst)
    !link_up |-> slot_valid == '0) else $error("live slot while link down");
  a_bv_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[132] |-> m_tdata[0]) else $error("byte without event");
  a_disc_run: assert property (@(posedge clk) disable iff (rst)
    run_discarded |-> run_active) else $error("discard outside run");

endmodule
